@@ hdl/dcd_pkg.sv @@
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared constants for the double clap detector: register map, reset
// values, field widths and saturation limits.
// ----------------------------------------------------------------------------
package dcd_pkg;

  // Default sample width of the ADC stream
  localparam int SampleBitsDefault = 12;

  // Field widths
  localparam int AmpBits   = 12;
  localparam int LenBits   = 10;
  localparam int SpaceBits = 8;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 12;

  // Register map
  localparam logic [CfgIdxBits-1:0] RegThreshold = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegWinLen    = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegMinSpace  = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegMaxSpace  = 2'd3;

  // Register reset values (205 counts is about 0.05 of full scale)
  localparam logic [AmpBits-1:0]   ThresholdRst = 12'd205;
  localparam logic [LenBits-1:0]   WinLenRst    = 10'd50;
  localparam logic [SpaceBits-1:0] MinSpaceRst  = 8'd1;
  localparam logic [SpaceBits-1:0] MaxSpaceRst  = 8'd5;

  // Saturation limits
  localparam logic [AmpBits-1:0]   AmpMax   = '1;
  localparam logic [SpaceBits-1:0] SpaceMax = '1;

endpackage

@@ hdl/double_clap_detector_unit.sv @@
// ----------------------------------------------------------------------------
// double_clap_detector_unit
// Windowed peak-to-peak amplitude of an ADC stream with double clap
// detection.
// ----------------------------------------------------------------------------
// The unit takes one sample word per cycle. Each sample updates the running
// min/max of the current window in the cycle it is accepted; the word that
// closes a window loads one result (amplitude, clap flag) into the output
// register, which is visible the next cycle. Samples keep flowing while that
// result is taken; input ready drops only while the output register holds a
// result the consumer has not taken. Sustained rate is one sample per clock.
// Config writes (index 0 threshold, 1 window length, 2 min spacing,
// 3 max spacing) are always ready and should be issued while the unit is idle.
// ----------------------------------------------------------------------------
module double_clap_detector_unit #(
  parameter int SAMPLE_BITS = dcd_pkg::SampleBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Sample channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [SAMPLE_BITS-1:0]           sample_i,
  // Result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [dcd_pkg::AmpBits-1:0]      window_amplitude_o,
  output logic                             clap_detected_o,
  // Config write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dcd_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [dcd_pkg::CfgDataBits-1:0]  cfg_data_i
);

  localparam int AmpW = (SAMPLE_BITS > dcd_pkg::AmpBits) ? SAMPLE_BITS : dcd_pkg::AmpBits;

  logic [dcd_pkg::AmpBits-1:0]   thresh_q;
  logic [dcd_pkg::LenBits-1:0]   win_len_q;
  logic [dcd_pkg::SpaceBits-1:0] min_sp_q, max_sp_q;

  logic                          armed_d, armed_q;
  logic [dcd_pkg::SpaceBits-1:0] spacing_d, spacing_q;
  logic                          out_valid_d, out_valid_q;
  logic [dcd_pkg::AmpBits-1:0]   amp_d, amp_q;
  logic                          clap_d, clap_q;

  logic                          step;
  logic                          win_done;
  logic [SAMPLE_BITS-1:0]        win_amp;
  logic [AmpW-1:0]               amp_ext;
  logic                          loud;
  logic                          in_range;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= dcd_pkg::ThresholdRst;
      win_len_q <= dcd_pkg::WinLenRst;
      min_sp_q  <= dcd_pkg::MinSpaceRst;
      max_sp_q  <= dcd_pkg::MaxSpaceRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dcd_pkg::RegThreshold: thresh_q  <= cfg_data_i;
        dcd_pkg::RegWinLen:    win_len_q <= cfg_data_i[dcd_pkg::LenBits-1:0];
        dcd_pkg::RegMinSpace:  min_sp_q  <= cfg_data_i[dcd_pkg::SpaceBits-1:0];
        dcd_pkg::RegMaxSpace:  max_sp_q  <= cfg_data_i[dcd_pkg::SpaceBits-1:0];
        default: ;
      endcase
    end
  end

  // Window tracker
  dcd_window #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .sample_i   (sample_i),
    .win_len_i  (win_len_q),
    .win_done_o (win_done),
    .amp_o      (win_amp)
  );

  // Loudness uses the unsaturated amplitude
  assign amp_ext  = AmpW'(win_amp);
  assign loud     = amp_ext >= AmpW'(thresh_q);
  assign in_range = (spacing_q >= min_sp_q) && (spacing_q <= max_sp_q);

  // Clap decision and result register load
  always_comb begin
    armed_d     = armed_q;
    spacing_d   = spacing_q;
    out_valid_d = out_valid_q && !out_ready_i;
    amp_d       = amp_q;
    clap_d      = clap_q;
    if (step && win_done) begin
      out_valid_d = 1'b1;
      amp_d       = (amp_ext > AmpW'(dcd_pkg::AmpMax)) ? dcd_pkg::AmpMax
                                                      : amp_ext[dcd_pkg::AmpBits-1:0];
      clap_d      = 1'b0;
      if (!armed_q) begin
        if (loud) begin
          armed_d   = 1'b1;
          spacing_d = '0;
        end
      end else begin
        if (spacing_q > max_sp_q) armed_d = 1'b0;
        if (loud && in_range) begin
          clap_d    = 1'b1;
          armed_d   = 1'b0;
          spacing_d = '0;
        end else if (spacing_q != dcd_pkg::SpaceMax) begin
          spacing_d = spacing_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      spacing_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      armed_q     <= armed_d;
      spacing_q   <= spacing_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    amp_q  <= amp_d;
    clap_q <= clap_d;
  end

  assign out_valid_o        = out_valid_q;
  assign window_amplitude_o = amp_q;
  assign clap_detected_o    = clap_q;

endmodule

@@ hdl/dcd_window.sv @@
// ----------------------------------------------------------------------------
// dcd_window
// Running min/max tracker over fixed-length sample windows. On the word
// that closes a window it flags the end and gives the peak-to-peak value.
// ----------------------------------------------------------------------------
module dcd_window #(
  parameter int SAMPLE_BITS = dcd_pkg::SampleBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  input  logic [dcd_pkg::LenBits-1:0]  win_len_i,
  output logic                         win_done_o,
  output logic [SAMPLE_BITS-1:0]       amp_o
);

  logic [dcd_pkg::LenBits-1:0] count_d, count_q;
  logic [SAMPLE_BITS-1:0]      low_d, low_q;
  logic [SAMPLE_BITS-1:0]      high_d, high_q;
  logic [SAMPLE_BITS-1:0]      low_nx, high_nx;
  logic [dcd_pkg::LenBits:0]   count_inc;

  // Extremes including the current sample
  assign low_nx  = (sample_i < low_q)  ? sample_i : low_q;
  assign high_nx = (sample_i > high_q) ? sample_i : high_q;

  // Window closes once the count reaches the (possibly lowered) length
  assign count_inc  = {1'b0, count_q} + 1'b1;
  assign win_done_o = !(count_inc < {1'b0, win_len_i});
  assign amp_o      = (high_nx >= low_nx) ? (high_nx - low_nx) : '0;

  // Next-state logic
  always_comb begin
    count_d = count_q;
    low_d   = low_q;
    high_d  = high_q;
    if (step_i) begin
      if (win_done_o) begin
        count_d = '0;
        low_d   = '1;
        high_d  = '0;
      end else begin
        count_d = count_inc[dcd_pkg::LenBits-1:0];
        low_d   = low_nx;
        high_d  = high_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      low_q   <= '1;
      high_q  <= '0;
    end else begin
      count_q <= count_d;
      low_q   <= low_d;
      high_q  <= high_d;
    end
  end

endmodule
